[design/skpl_pkg.sv]
// shared types, register codes, constants and table functions of the soft knee limiter
package skpl_pkg;

    localparam int GC_W = 18;

    localparam logic [2:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [2:0] CFG_KNEE_SPAN    = 3'd1;
    localparam logic [2:0] CFG_ATTACK       = 3'd2;
    localparam logic [2:0] CFG_RELEASE      = 3'd3;
    localparam logic [2:0] CFG_MAKEUP_DB    = 3'd4;
    localparam logic [2:0] CFG_MAKEUP_FIXED = 3'd5;

    localparam logic signed [14:0] RST_THRESHOLD    = -15'sd2560;
    localparam logic [12:0]        RST_KNEE_SPAN    = 13'd0;
    localparam logic [15:0]        RST_ATTACK       = 16'd0;
    localparam logic [15:0]        RST_RELEASE      = 16'd65521;
    localparam logic signed [13:0] RST_MAKEUP_DB    = 14'sd0;
    localparam logic               RST_MAKEUP_FIXED = 1'b1;

    localparam logic [18:0] DB_SCALE  = 19'd394566;
    localparam logic [21:0] EXP_SCALE = 22'd2786635;

    typedef struct packed {
        logic signed [14:0] threshold;
        logic [12:0]        knee_span;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic signed [13:0] makeup_db;
        logic               makeup_fixed;
    } t_cfg;

    function automatic logic [16:0] log_rom(input int unsigned i, input int unsigned lb);
        logic [63:0] m;
        logic [16:0] r;
        r = 17'd0;
        m = 64'd0;
        if (i >= (32'd1 << lb)) begin
            r = 17'd65536;
        end else begin
            m = (64'd1 << 30) + ((64'(i) << 30) >> lb);
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                r = {r[15:0], 1'b0};
                if (m >= (64'd1 << 31)) begin
                    r[0] = 1'b1;
                    m = m >> 1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = v_in;
        res = 64'd0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > v) b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [30:0] exp_root(input int unsigned k);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int j = 1; j <= 16; j++) begin
            if (j <= k) r = isqrt64(r << 30);
        end
        return r[30:0];
    endfunction

endpackage

[design/skpl_front.sv]
// front end: sample accept, log level, static curve with shared knee divider
module skpl_front #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_push,
    output logic                                          o_full,
    input  logic signed [SAMPLE_WIDTH-1:0]                i_sample_in,
    input  skpl_pkg::t_cfg                                i_cfg,
    output logic                                          o_job_push,
    input  logic                                          i_job_full,
    output logic [SAMPLE_WIDTH+2*skpl_pkg::GC_W+1:0]      o_job_data
);
    import skpl_pkg::*;

    localparam int LOG_BITS = $clog2(LOG_TABLE_DEPTH);
    localparam logic [21:0] NEG_FULL = 22'((SAMPLE_WIDTH - 1) * 65536);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_ROM, S_INTERP, S_LEVEL, S_DB, S_CURVE, S_DIV, S_PUSH
    } t_state;

    t_state                    r_state;
    logic                      r_neg;
    logic                      r_zero;
    logic [SAMPLE_WIDTH-1:0]   r_mag;
    logic [31:0]               r_mn;
    logic [4:0]                r_shift;
    logic [2:0]                r_step;
    logic [16:0]               r_a;
    logic [16:0]               r_b;
    logic [31:0]               r_rem;
    logic [48:0]               r_ip;
    logic [40:0]               r_lp;
    logic signed [15:0]        r_xdb;
    logic signed [15:0]        r_x;
    logic                      r_sel;
    logic [29:0]               r_num;
    logic [28:0]               r_den;
    logic [13:0]               r_q;
    logic [3:0]                r_cnt;
    logic signed [GC_W-1:0]    r_c0;
    logic signed [GC_W-1:0]    r_gc;
    logic signed [GC_W-1:0]    r_mk;

    logic [16:0]               w_rom [LOG_TABLE_DEPTH+1];
    logic [SAMPLE_WIDTH-1:0]   w_mag_in;
    logic [5:0]                w_amt;
    logic                      w_hi_zero;
    logic [31:0]               w_frac32;
    logic [LOG_BITS:0]         w_idx;
    logic [LOG_BITS:0]         w_idx1;
    logic [4:0]                w_p;
    logic [21:0]               w_lg;
    logic [21:0]               w_negv;
    logic [16:0]               w_dbm;
    logic signed [18:0]        w_x19;
    logic signed [18:0]        w_thr19;
    logic signed [18:0]        w_kn19;
    logic signed [18:0]        w_d2s;
    logic [14:0]               w_d2;
    logic [29:0]               w_sq;
    logic                      w_hard;
    logic                      w_direct;
    logic signed [GC_W-1:0]    w_direct_res;
    logic                      w_ge;
    logic [13:0]               w_qn;
    logic                      w_done;
    logic signed [GC_W-1:0]    w_res;

    for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = log_rom(g, LOG_BITS);
    end

    assign w_mag_in  = i_sample_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_sample_in)
                                                   : SAMPLE_WIDTH'(i_sample_in);
    assign w_amt     = 6'd16 >> r_step;
    assign w_hi_zero = (r_mn >> (6'd32 - w_amt)) == 32'd0;
    assign w_frac32  = {r_mn[30:0], 1'b0};
    assign w_idx     = {1'b0, w_frac32[31 -: LOG_BITS]};
    assign w_idx1    = w_idx + 1'b1;
    assign w_p       = 5'd31 - r_shift;
    assign w_lg      = {1'b0, w_p, 16'd0} + 22'(r_a) + 22'(r_ip[48:32]);
    assign w_negv    = (NEG_FULL > w_lg) ? NEG_FULL - w_lg : 22'd0;
    assign w_dbm     = 17'((r_lp + 41'd8388608) >> 24);

    // static curve on r_x
    assign w_x19   = 19'(r_x);
    assign w_thr19 = 19'(i_cfg.threshold);
    assign w_kn19  = 19'(i_cfg.knee_span);
    assign w_hard  = i_cfg.knee_span < 13'd3;
    assign w_d2s   = (w_x19 <<< 1) - (w_thr19 <<< 1) + w_kn19;
    assign w_d2    = w_d2s[14:0];
    assign w_sq    = w_d2 * w_d2;

    always_comb begin
        w_direct     = 1'b1;
        w_direct_res = GC_W'(r_x);
        if (w_hard) begin
            w_direct_res = (w_x19 < w_thr19) ? GC_W'(r_x) : GC_W'(i_cfg.threshold);
        end else if ((w_x19 <<< 1) < (w_thr19 <<< 1) - w_kn19) begin
            w_direct_res = GC_W'(r_x);
        end else if ((w_x19 <<< 1) > (w_thr19 <<< 1) + w_kn19) begin
            w_direct_res = GC_W'(i_cfg.threshold);
        end else begin
            w_direct = 1'b0;
        end
    end

    assign w_ge = {1'b0, r_num} >= {2'b0, r_den};
    assign w_qn = r_q | (14'(w_ge) << r_cnt);

    always_comb begin
        w_done = 1'b0;
        w_res  = w_direct_res;
        if (r_state == S_CURVE && w_direct) begin
            w_done = 1'b1;
        end else if (r_state == S_DIV && r_cnt == 4'd0) begin
            w_done = 1'b1;
            w_res  = GC_W'(r_x) - GC_W'(w_qn);
        end
    end

    assign o_full     = (r_state != S_IDLE);
    assign o_job_push = (r_state == S_PUSH);
    assign o_job_data = {r_neg, r_zero, r_mag, r_gc, r_mk};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_neg   <= i_sample_in[SAMPLE_WIDTH-1];
                        r_mag   <= w_mag_in;
                        r_mn    <= 32'(w_mag_in);
                        r_shift <= 5'd0;
                        r_step  <= 3'd0;
                        r_gc    <= '0;
                        r_mk    <= '0;
                        if (i_sample_in == '0) begin
                            r_zero  <= 1'b1;
                            r_state <= S_PUSH;
                        end else begin
                            r_zero  <= 1'b0;
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (w_hi_zero) begin
                        r_mn    <= r_mn << w_amt;
                        r_shift <= r_shift + w_amt[4:0];
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd4) r_state <= S_ROM;
                end
                S_ROM: begin
                    r_a     <= w_rom[w_idx];
                    r_b     <= w_rom[w_idx1];
                    r_rem   <= w_frac32 << LOG_BITS;
                    r_state <= S_INTERP;
                end
                S_INTERP: begin
                    r_ip    <= (r_b - r_a) * r_rem;
                    r_state <= S_LEVEL;
                end
                S_LEVEL: begin
                    r_lp    <= w_negv * DB_SCALE;
                    r_state <= S_DB;
                end
                S_DB: begin
                    r_xdb   <= (w_dbm > 17'd32768) ? -16'sd32768 : 16'(-w_dbm);
                    r_x     <= 16'sd0;
                    r_sel   <= 1'b0;
                    r_state <= S_CURVE;
                end
                S_CURVE: begin
                    if (!w_direct) begin
                        r_num   <= w_sq + 30'({i_cfg.knee_span, 2'b00});
                        r_den   <= 29'({i_cfg.knee_span, 3'b000}) << 13;
                        r_q     <= 14'd0;
                        r_cnt   <= 4'd13;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_ge) r_num <= r_num - 30'(r_den);
                    r_den <= r_den >> 1;
                    r_q   <= w_qn;
                    r_cnt <= r_cnt - 4'd1;
                end
                S_PUSH: begin
                    if (!i_job_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_done) begin
                if (!r_sel) begin
                    r_c0    <= w_res;
                    r_x     <= r_xdb;
                    r_sel   <= 1'b1;
                    r_state <= S_CURVE;
                end else begin
                    r_gc    <= w_res - GC_W'(r_xdb);
                    r_mk    <= i_cfg.makeup_fixed ? GC_W'(i_cfg.makeup_db) : -r_c0;
                    r_state <= S_PUSH;
                end
            end
        end
    end

endmodule

[design/skpl_fifo.sv]
// two-entry item queue between front and back
module skpl_fifo #(
    parameter int WIDTH = 62
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

[design/skpl_back.sv]
// back end: gain smoothing, makeup, exponent chain, gain multiply and output register
module skpl_back #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_job_empty,
    output logic                                     o_job_pop,
    input  logic [SAMPLE_WIDTH+2*skpl_pkg::GC_W+1:0] i_job_data,
    input  skpl_pkg::t_cfg                           i_cfg,
    input  logic                                     i_pop,
    output logic                                     o_empty,
    output logic signed [SAMPLE_WIDTH-1:0]           o_sample_out,
    output logic signed [15:0]                       o_gain_db
);
    import skpl_pkg::*;

    localparam logic [63:0] LIM = 64'd1 << (SAMPLE_WIDTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SMUL, S_SADD, S_EMUL, S_EADJ, S_CHAIN, S_PMUL, S_SHIFT, S_OUT
    } t_state;

    t_state                  r_state;
    logic                    r_neg;
    logic [SAMPLE_WIDTH-1:0] r_mag;
    logic signed [GC_W-1:0]  r_gc;
    logic signed [GC_W-1:0]  r_mk;
    logic signed [GC_W-1:0]  r_sg;
    logic signed [35:0]      r_dp;
    logic signed [15:0]      r_gm;
    logic signed [39:0]      r_ep;
    logic [15:0]             r_frac;
    logic signed [7:0]       r_n;
    logic [30:0]             r_m;
    logic [4:0]              r_k;
    logic [63:0]             r_prod;
    logic [SAMPLE_WIDTH-1:0] r_ws;
    logic [15:0]             r_wg;
    logic [SAMPLE_WIDTH-1:0] r_ys;
    logic [15:0]             r_yg;
    logic                    r_ov;

    logic [30:0]             w_root [16];
    logic [15:0]             w_alpha;
    logic signed [18:0]      w_diff;
    logic signed [20:0]      w_sgn;
    logic signed [18:0]      w_sum;
    logic signed [23:0]      w_e;
    logic [63:0]             w_mr;
    logic [5:0]              w_sh;
    logic [63:0]             w_y;
    logic [SAMPLE_WIDTH-1:0] w_ysat;
    logic                    w_load;

    for (genvar g = 0; g < 16; g++) begin : g_root
        assign w_root[g] = exp_root(g + 1);
    end

    assign w_alpha = (r_gc <= r_sg) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    assign w_diff  = 19'(r_sg) - 19'(r_gc);
    assign w_sgn   = 21'(r_gc) + 21'((r_dp + 36'sd32768) >>> 16);
    assign w_sum   = 19'($signed(w_sgn[GC_W-1:0])) + 19'(r_mk);
    assign w_e     = 24'((r_ep + 40'sd32768) >>> 16);
    assign w_mr    = r_m * w_root[4'(r_k - 5'd1)];
    assign w_sh    = 6'(8'sd30 - r_n);
    assign w_y     = (r_prod + (64'd1 << (w_sh - 6'd1))) >> w_sh;

    always_comb begin
        if (r_neg) begin
            w_ysat = (w_y > LIM) ? LIM[SAMPLE_WIDTH-1:0] : SAMPLE_WIDTH'(-w_y);
        end else begin
            w_ysat = (w_y > LIM - 64'd1) ? SAMPLE_WIDTH'(LIM - 64'd1) : w_y[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_job_pop    = (r_state == S_IDLE);
    assign w_load       = (r_state == S_OUT) && (!r_ov || i_pop);
    assign o_empty      = !r_ov;
    assign o_sample_out = r_ys;
    assign o_gain_db    = r_yg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sg    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        {r_neg, r_mag, r_gc, r_mk} <= {i_job_data[SAMPLE_WIDTH+2*GC_W+1],
                                                       i_job_data[SAMPLE_WIDTH+2*GC_W-1:0]};
                        if (i_job_data[SAMPLE_WIDTH+2*GC_W]) begin
                            r_ws    <= '0;
                            r_wg    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SMUL;
                        end
                    end
                end
                S_SMUL: begin
                    r_dp    <= $signed({1'b0, w_alpha}) * w_diff;
                    r_state <= S_SADD;
                end
                S_SADD: begin
                    r_sg <= w_sgn[GC_W-1:0];
                    priority if (w_sum > 19'sd32767) r_gm <= 16'sd32767;
                    else if (w_sum < -19'sd32768) r_gm <= -16'sd32768;
                    else r_gm <= w_sum[15:0];
                    r_state <= S_EMUL;
                end
                S_EMUL: begin
                    r_ep    <= r_gm * $signed({1'b0, EXP_SCALE});
                    r_state <= S_EADJ;
                end
                S_EADJ: begin
                    r_n     <= w_e[23:16];
                    r_frac  <= w_e[15:0];
                    r_m     <= 31'd1 << 30;
                    r_k     <= 5'd1;
                    r_state <= S_CHAIN;
                end
                S_CHAIN: begin
                    if (r_frac[4'(5'd16 - r_k)]) r_m <= 31'((w_mr + 64'd536870912) >> 30);
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'd16) r_state <= S_PMUL;
                end
                S_PMUL: begin
                    r_prod  <= r_mag * r_m;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_ws    <= w_ysat;
                    r_wg    <= r_gm;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_ys    <= r_ws;
                        r_yg    <= r_wg;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_chain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAIN) |-> (r_k != 5'd0 && r_k <= 5'd16))
        else $error("exponent chain step out of range");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_pop) |=> r_ov)
        else $error("waiting result dropped");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_ov || i_pop))
        else $error("result register overwritten");

endmodule

[design/soft_knee_peak_limiter.sv]
// Soft knee peak limiter top level: config registers, front end, item queue, back end.
// Each item passes the back end, where the exponent chain has 16 steps (one 31x31
// product a cycle), and the front end, where with a soft knee the curve runs twice
// (at 0 dB and at the sample level) through a one-bit-per-cycle divider of 14 steps;
// the sustained rate is set by the slower of the two halves.
// The two halves are joined by a two-entry queue and a result register, so a new
// sample is taken while a result waits. Zero samples pass as zero with gain 0.
// LOG_TABLE_DEPTH must be a power of two. cfg_ready is always high.
module soft_knee_peak_limiter #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic signed [15:0]             o_gain_db,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import skpl_pkg::*;

    localparam int JOB_W = SAMPLE_WIDTH + 2 * GC_W + 2;

    t_cfg             r_cfg;
    logic             w_job_push;
    logic             w_job_full;
    logic [JOB_W-1:0] w_job_in;
    logic             w_job_pop;
    logic             w_job_empty;
    logic [JOB_W-1:0] w_job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= RST_THRESHOLD;
            r_cfg.knee_span     <= RST_KNEE_SPAN;
            r_cfg.attack_coeff  <= RST_ATTACK;
            r_cfg.release_coeff <= RST_RELEASE;
            r_cfg.makeup_db     <= RST_MAKEUP_DB;
            r_cfg.makeup_fixed  <= RST_MAKEUP_FIXED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:    r_cfg.threshold     <= i_cfg_data[14:0];
                CFG_KNEE_SPAN:    r_cfg.knee_span     <= i_cfg_data[12:0];
                CFG_ATTACK:       r_cfg.attack_coeff  <= i_cfg_data;
                CFG_RELEASE:      r_cfg.release_coeff <= i_cfg_data;
                CFG_MAKEUP_DB:    r_cfg.makeup_db     <= i_cfg_data[13:0];
                CFG_MAKEUP_FIXED: r_cfg.makeup_fixed  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    skpl_front #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_sample_in(i_sample_in),
        .i_cfg      (r_cfg),
        .o_job_push (w_job_push),
        .i_job_full (w_job_full),
        .o_job_data (w_job_in)
    );

    skpl_fifo #(
        .WIDTH(JOB_W)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_job_push),
        .o_full (w_job_full),
        .i_data (w_job_in),
        .i_pop  (w_job_pop),
        .o_empty(w_job_empty),
        .o_data (w_job_out)
    );

    skpl_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_job_data  (w_job_out),
        .i_cfg       (r_cfg),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_sample_out(o_sample_out),
        .o_gain_db   (o_gain_db)
    );

endmodule

[sim/tb.sv]
// testbench for the soft knee peak limiter: directed table, random samples, predictor check
`timescale 1ns / 100ps

module tb;
    import skpl_pkg::*;

    localparam int SW = 24;
    localparam longint unsigned TAB_D = 256;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_push = 1'b0;
    logic          o_full;
    logic [SW-1:0] i_sample_in = '0;
    logic          o_empty;
    logic          i_pop = 1'b0;
    logic [SW-1:0] o_sample_out;
    logic [15:0]   o_gain_db;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = CFG_THRESHOLD;
    logic [15:0]   i_cfg_data = '0;

    soft_knee_peak_limiter u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full), .i_sample_in(i_sample_in),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_sample_out(o_sample_out), .o_gain_db(o_gain_db),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        logic [SW-1:0] sample;
        logic [15:0]   gain;
    } limited_t;

    limited_t pending_q[$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_cfg = 0;
    bit steady = 1'b0;
    int pop_hold = 0;

    // shadow registers and smoothing state
    int thr_db, knee_db, mk_db;
    longint atk_a, rel_a;
    bit mk_fixed;
    int smooth_db;

    function automatic longint unsigned log2_entry(longint unsigned i);
        longint unsigned m, r;
        if (i >= TAB_D) return 65536;
        m = (64'd1 << 30) + ((i << 30) / TAB_D);
        r = 0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd1 << 31)) begin
                r = r | 1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v_in);
        longint unsigned v, res, b;
        v = v_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int level_dbfs(longint unsigned mag);
        int p;
        longint unsigned f32, sc, idx, rem, a, b, lg, ng;
        longint db;
        p = 0;
        f32 = 0;
        while (p < 63 && (mag >> (p + 1)) != 0) p++;
        if (p > 0) f32 = (mag - (64'd1 << p)) << (32 - p);
        sc = f32 * TAB_D;
        idx = sc >> 32;
        rem = sc & 64'hFFFF_FFFF;
        a = log2_entry(idx);
        b = log2_entry(idx + 1);
        lg = longint'(p) * 65536 + a + (((b - a) * rem) >> 32);
        ng = longint'(SW - 1) * 65536;
        ng = (ng > lg) ? ng - lg : 0;
        db = -longint'((ng * 394566 + (64'd1 << 23)) >> 24);
        if (db < -32768) db = -32768;
        return int'(db);
    endfunction

    function automatic int knee_curve(int xdb);
        longint d2;
        if (knee_db < 3) return (xdb < thr_db) ? xdb : thr_db;
        if (2 * xdb < 2 * thr_db - knee_db) return xdb;
        if (2 * xdb > 2 * thr_db + knee_db) return thr_db;
        d2 = 2 * xdb - 2 * thr_db + knee_db;
        return xdb - int'((d2 * d2 + 4 * longint'(knee_db)) / (8 * longint'(knee_db)));
    endfunction

    task automatic limit_sample(input logic [SW-1:0] s, output limited_t res);
        longint x, dp, e, eb, n, y, lim;
        longint unsigned mag, frac, m, r, prod;
        int xdb, gc, mk, gm, sh;
        x = longint'($signed(s));
        res.sample = '0;
        res.gain = '0;
        if (x == 0) return;
        mag = (x < 0) ? longint'(-x) : x;
        xdb = level_dbfs(mag);
        gc = knee_curve(xdb) - xdb;
        dp = ((gc <= smooth_db) ? atk_a : rel_a) * longint'(smooth_db - gc);
        smooth_db = gc + int'((dp + 32768) >>> 16);
        mk = mk_fixed ? mk_db : -knee_curve(0);
        gm = smooth_db + mk;
        if (gm > 32767) gm = 32767;
        if (gm < -32768) gm = -32768;
        e = (longint'(gm) * 2786635 + 32768) >>> 16;
        eb = e + 64 * 65536;
        n = (eb >>> 16) - 64;
        frac = eb & 16'hFFFF;
        m = 64'd1 << 30;
        r = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            r = root_floor(r << 30);
            if ((frac >> (16 - k)) & 1) m = (m * r + (64'd1 << 29)) >> 30;
        end
        prod = mag * m;
        sh = int'(30 - n);
        y = longint'((prod + (64'd1 << (sh - 1))) >> sh);
        lim = 64'sd1 << (SW - 1);
        if (x < 0) begin
            y = -y;
            if (y < -lim) y = -lim;
        end else if (y > lim - 1) begin
            y = lim - 1;
        end
        res.sample = y[SW-1:0];
        res.gain = gm[15:0];
    endtask

    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        int r;
        logic [SW-1:0] v;
        r = $urandom_range(0, 9);
        v = SW'($urandom);
        case (r)
            0: v = '0;
            1: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2, 3, 4: v = SW'($urandom >> $urandom_range(8, 31));
            default: ;
        endcase
        if (r >= 2 && r <= 4 && $urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic send_sample(input logic [SW-1:0] s, input bit typed, input limited_t want);
        limited_t got;
        int g;
        i_sample_in <= s;
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        if (typed) got = want;
        else limit_sample(s, got);
        pending_q.push_back(got);
        n_items++;
        g = idle_len();
        if (g > 0) begin
            i_push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        i_cfg_index <= idx;
        i_cfg_data <= d;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD:    thr_db = int'($signed(d[14:0]));
            CFG_KNEE_SPAN:    knee_db = int'(d[12:0]);
            CFG_ATTACK:       atk_a = longint'(d);
            CFG_RELEASE:      rel_a = longint'(d);
            CFG_MAKEUP_DB:    mk_db = int'($signed(d[13:0]));
            CFG_MAKEUP_FIXED: mk_fixed = d[0];
            default: ;
        endcase
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [15:0] t, input logic [15:0] k, input logic [15:0] a,
                             input logic [15:0] r, input logic [15:0] mg, input logic [15:0] mf);
        write_reg(CFG_THRESHOLD, t);
        write_reg(CFG_KNEE_SPAN, k);
        write_reg(CFG_ATTACK, a);
        write_reg(CFG_RELEASE, r);
        write_reg(CFG_MAKEUP_DB, mg);
        write_reg(CFG_MAKEUP_FIXED, mf);
    endtask

    task automatic run_random(input int count);
        limited_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_drained();
            send_sample(rand_sample(), 1'b0, none);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        limited_t want;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                n_results++;
                if (pending_q.size() == 0) begin
                    errors++;
                    $error("unexpected item: sample_out %0d gain_db %0d",
                           $signed(o_sample_out), $signed(o_gain_db));
                end else begin
                    want = pending_q.pop_front();
                    if (o_sample_out !== want.sample) begin
                        errors++;
                        $error("sample_out expected %0d got %0d",
                               $signed(want.sample), $signed(o_sample_out));
                    end
                    if (o_gain_db !== want.gain) begin
                        errors++;
                        $error("gain_db expected %0d got %0d",
                               $signed(want.gain), $signed(o_gain_db));
                    end
                end
            end
            if (steady) begin
                i_pop <= 1'b1;
            end else if (pop_hold > 0) begin
                pop_hold <= pop_hold - 1;
                i_pop <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1: pop_hold <= $urandom_range(1, 3);
                    2: pop_hold <= $urandom_range(20, 80);
                    default: ;
                endcase
                i_pop <= 1'b1;
            end
        end
    end

    typedef struct {
        logic [SW-1:0] s;
        bit            typed;
    } table_row_t;

    table_row_t dir_rows[14] = '{
        '{24'h000000, 1'b1}, '{24'h000001, 1'b0}, '{24'hFFFFFF, 1'b0},
        '{24'h7FFFFF, 1'b0}, '{24'h800000, 1'b0}, '{24'h800001, 1'b0},
        '{24'h000002, 1'b0}, '{24'h400000, 1'b0}, '{24'hC00000, 1'b0},
        '{24'h0000FF, 1'b0}, '{24'h000100, 1'b0}, '{24'h000000, 1'b1},
        '{24'h003039, 1'b0}, '{24'hFFFFFD, 1'b0}
    };

    initial begin
        limited_t zero_res;
        int wait_cnt;
        zero_res = '{default: '0};
        thr_db = int'(RST_THRESHOLD);
        knee_db = int'(RST_KNEE_SPAN);
        atk_a = longint'(RST_ATTACK);
        rel_a = longint'(RST_RELEASE);
        mk_db = int'(RST_MAKEUP_DB);
        mk_fixed = RST_MAKEUP_FIXED;
        smooth_db = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_sample(dir_rows[i].s, dir_rows[i].typed, zero_res);
        wait_drained();

        // hard knee at full scale, instant attack and release
        write_all(16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        steady = 1'b1;
        run_random(100);
        steady = 1'b0;
        // low threshold, wide knee, slowest smoothing, high makeup
        write_all(16'hCE00, 16'd5120, 16'hFFFF, 16'hFFFF, 16'd6144, 16'd1);
        run_random(110);
        // auto makeup with a soft knee
        write_all(16'hF600, 16'd1536, 16'd40000, 16'd65521, 16'd0, 16'd0);
        run_random(110);
        // just above the hard knee limit, negative makeup
        write_all(16'hFB00, 16'd3, 16'd1000, 16'd60000, 16'h3600, 16'd1);
        run_random(110);
        write_all(16'hF000, 16'd2, 16'd30000, 16'd100, 16'd0, 16'd0);
        run_random(100);
        for (int p = 0; p < 4; p++) begin
            write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            run_random(105);
        end

        wait_cnt = 0;
        while (pending_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (200) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            errors++;
            $error("%0d expected items never came out", pending_q.size());
        end
        $display("ran %0d samples and %0d results through %0d register writes",
                 n_items, n_results, n_cfg);
        $display("covered hard and soft knee, fixed and auto makeup, random register values");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
design/skpl_pkg.sv
design/skpl_front.sv
design/skpl_fifo.sv
design/skpl_back.sv
design/soft_knee_peak_limiter.sv
sim/tb.sv
